>>> design/htc_pkg.sv
// ----------------------------------------------------------------------------
// htc_pkg: tone curve shared definitions
// Widths, register map, reset values and types of the Hermite tone curve.
// ----------------------------------------------------------------------------
package htc_pkg;

    localparam int CURVE_ENTRIES = 512;
    localparam int IDX_W         = 9;
    localparam int CI_W          = $clog2(CURVE_ENTRIES);
    localparam int NW            = $clog2(CURVE_ENTRIES + 1);
    localparam int PW            = 16 + NW;
    localparam int DIV_STEPS     = 16;
    localparam int SLOPE_STEPS   = 32;
    localparam int CNT_W         = $clog2(SLOPE_STEPS);

    localparam logic [15:0] ONE_Q15     = 16'd32768;
    localparam logic [15:0] KNEE1_RESET = 16'd6554;
    localparam logic [15:0] KNEE2_RESET = 16'd26214;

    typedef enum logic [1:0] {
        REG_KNEE1_X,
        REG_KNEE1_Y,
        REG_KNEE2_X,
        REG_KNEE2_Y
    } reg_idx_t;

    typedef enum logic [1:0] {
        SLP_INIT,
        SLP_MID,
        SLP_LAST
    } slp_sel_t;

    typedef enum logic [2:0] {
        SL_IDLE,
        SL_LOAD,
        SL_DIV,
        SL_STORE,
        SL_LOW,
        SL_HIGH
    } slp_state_t;

    typedef struct packed {
        logic [15:0] y0;
        logic [15:0] y1;
        logic [15:0] d;
        logic [31:0] m0;
        logic [31:0] m1;
    } seg_t;

endpackage

>>> design/hermite_tone_curve_lut.sv
// ----------------------------------------------------------------------------
// hermite_tone_curve_lut: three-segment cubic Hermite tone curve
// Maps a curve table index to an 8-bit tone level through two knee points.
// ----------------------------------------------------------------------------
// One index is accepted per cycle while busy is low; each result is strobed
// on done for a single cycle, and the receiver cannot stall it. Each index
// passes through segment select, a 16-stage restoring divider and a
// five-stage polynomial and saturation pipeline, every stage registered.
// After reset and after every register write, busy stays high while a
// shared shift-subtract divider works out the three tangents, 32 steps each.
module hermite_tone_curve_lut (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [htc_pkg::IDX_W-1:0]  entry_index,
    output logic                       done,
    output logic [7:0]                 level,
    output logic                       clipped,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int PW = htc_pkg::PW;
    localparam int DS = htc_pkg::DIV_STEPS;
    localparam logic [PW-1:0] N_P = PW'(htc_pkg::CURVE_ENTRIES);
    localparam logic [PW-1:0] IMAX_P = PW'(htc_pkg::CURVE_ENTRIES - 1);

    function automatic logic [31:0] half_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        logic [32:0] r;
        s = {a[31], a} + {b[31], b};
        r = $signed(s + {32'd0, s[32]}) >>> 1;
        return r[31:0];
    endfunction

    // configuration registers
    logic [15:0] k1x_reg, k1y_reg, k2x_reg, k2y_reg;
    logic        wr_en;
    htc_pkg::reg_idx_t wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = htc_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1x_reg <= htc_pkg::KNEE1_RESET;
            k1y_reg <= htc_pkg::KNEE1_RESET;
            k2x_reg <= htc_pkg::KNEE2_RESET;
            k2y_reg <= htc_pkg::KNEE2_RESET;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                htc_pkg::REG_KNEE1_X: k1x_reg <= pwdata[15:0];
                htc_pkg::REG_KNEE1_Y: k1y_reg <= pwdata[15:0];
                htc_pkg::REG_KNEE2_X: k2x_reg <= pwdata[15:0];
                htc_pkg::REG_KNEE2_Y: k2y_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            htc_pkg::REG_KNEE1_X: prdata = {16'd0, k1x_reg};
            htc_pkg::REG_KNEE1_Y: prdata = {16'd0, k1y_reg};
            htc_pkg::REG_KNEE2_X: prdata = {16'd0, k2x_reg};
            htc_pkg::REG_KNEE2_Y: prdata = {16'd0, k2y_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // tangent sequencer
    htc_pkg::slp_state_t state_reg, state_next;
    htc_pkg::slp_sel_t   sel_reg, sel_next;
    logic [htc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0] drem_reg, drem_next;
    logic [31:0] dquo_reg, dquo_next;
    logic [15:0] ddiv_reg, ddiv_next;
    logic        dneg_reg, dneg_next, dzero_reg, dzero_next;
    logic [31:0] init_t_reg, init_t_next, mid_t_reg, mid_t_next, last_t_reg, last_t_next;
    logic [31:0] low_t_reg, low_t_next, high_t_reg, high_t_next;
    logic [16:0] dy, dx, ady, adx, shl;
    logic        ge;
    logic [32:0] qs;
    logic [31:0] qsat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= htc_pkg::SL_LOAD;
            sel_reg   <= htc_pkg::SLP_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drem_reg   <= drem_next;
        dquo_reg   <= dquo_next;
        ddiv_reg   <= ddiv_next;
        dneg_reg   <= dneg_next;
        dzero_reg  <= dzero_next;
        init_t_reg <= init_t_next;
        mid_t_reg  <= mid_t_next;
        last_t_reg <= last_t_next;
        low_t_reg  <= low_t_next;
        high_t_reg <= high_t_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        cnt_next    = cnt_reg;
        drem_next   = drem_reg;
        dquo_next   = dquo_reg;
        ddiv_next   = ddiv_reg;
        dneg_next   = dneg_reg;
        dzero_next  = dzero_reg;
        init_t_next = init_t_reg;
        mid_t_next  = mid_t_reg;
        last_t_next = last_t_reg;
        low_t_next  = low_t_reg;
        high_t_next = high_t_reg;

        case (sel_reg)
            htc_pkg::SLP_INIT:
            begin
                dy = {1'b0, k1y_reg};
                dx = {1'b0, k1x_reg};
            end
            htc_pkg::SLP_MID:
            begin
                dy = {1'b0, k2y_reg} - {1'b0, k1y_reg};
                dx = {1'b0, k2x_reg} - {1'b0, k1x_reg};
            end
            default:
            begin
                dy = {1'b0, htc_pkg::ONE_Q15} - {1'b0, k2y_reg};
                dx = {1'b0, htc_pkg::ONE_Q15} - {1'b0, k2x_reg};
            end
        endcase
        ady = dy[16] ? -dy : dy;
        adx = dx[16] ? -dx : dx;

        shl = {drem_reg, dquo_reg[31]};
        ge  = shl >= {1'b0, ddiv_reg};

        qs   = dneg_reg ? -{1'b0, dquo_reg} : {1'b0, dquo_reg};
        qsat = (qs[32] != qs[31]) ? (qs[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : qs[31:0];
        if (dzero_reg)
            qsat = 32'd0;

        case (state_reg)
            htc_pkg::SL_LOAD:
            begin
                dquo_next  = {ady[15:0], 16'd0};
                drem_next  = 16'd0;
                ddiv_next  = adx[15:0];
                dneg_next  = dy[16] ^ dx[16];
                dzero_next = (dx == 17'd0);
                cnt_next   = '0;
                state_next = htc_pkg::SL_DIV;
            end
            htc_pkg::SL_DIV:
            begin
                drem_next = ge ? 16'(shl - {1'b0, ddiv_reg}) : shl[15:0];
                dquo_next = {dquo_reg[30:0], ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == htc_pkg::CNT_W'(htc_pkg::SLOPE_STEPS - 1))
                    state_next = htc_pkg::SL_STORE;
            end
            htc_pkg::SL_STORE:
            begin
                case (sel_reg)
                    htc_pkg::SLP_INIT: init_t_next = qsat;
                    htc_pkg::SLP_MID:  mid_t_next  = qsat;
                    default:           last_t_next = qsat;
                endcase
                if (sel_reg == htc_pkg::SLP_LAST)
                    state_next = htc_pkg::SL_LOW;
                else
                begin
                    sel_next   = (sel_reg == htc_pkg::SLP_INIT) ? htc_pkg::SLP_MID
                                                                : htc_pkg::SLP_LAST;
                    state_next = htc_pkg::SL_LOAD;
                end
            end
            htc_pkg::SL_LOW:
            begin
                low_t_next = half_trunc(init_t_reg, mid_t_reg);
                state_next = htc_pkg::SL_HIGH;
            end
            htc_pkg::SL_HIGH:
            begin
                high_t_next = half_trunc(low_t_reg, last_t_reg);
                state_next  = htc_pkg::SL_IDLE;
            end
            default: ;
        endcase

        // restart on every write transfer
        if (wr_en)
        begin
            state_next = htc_pkg::SL_LOAD;
            sel_next   = htc_pkg::SLP_INIT;
        end
    end

    assign busy = (state_reg != htc_pkg::SL_IDLE);

    // stage 0: index capture
    logic                     v0_reg;
    logic [htc_pkg::CI_W-1:0] idx_reg, idx_next;
    logic [PW-1:0]            idx_ext;

    assign idx_ext  = PW'(entry_index);
    assign idx_next = (idx_ext > IMAX_P) ? htc_pkg::CI_W'(IMAX_P) : htc_pkg::CI_W'(idx_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    // stage 1: segment select
    logic [PW-1:0] pos, k1n, k2n, x0n, num_next, den_next;
    logic [15:0]   x0, x1;
    htc_pkg::seg_t seg_next;

    always_comb
    begin
        pos = PW'({idx_reg, 15'd0});
        k1n = PW'(k1x_reg) * N_P;
        k2n = PW'(k2x_reg) * N_P;
        if (pos < k1n)
        begin
            x0 = 16'd0;
            x1 = k1x_reg;
            seg_next.y0 = 16'd0;
            seg_next.y1 = k1y_reg;
            seg_next.m0 = init_t_reg;
            seg_next.m1 = low_t_reg;
        end
        else if (pos < k2n)
        begin
            x0 = k1x_reg;
            x1 = k2x_reg;
            seg_next.y0 = k1y_reg;
            seg_next.y1 = k2y_reg;
            seg_next.m0 = low_t_reg;
            seg_next.m1 = high_t_reg;
        end
        else
        begin
            x0 = k2x_reg;
            x1 = htc_pkg::ONE_Q15;
            seg_next.y0 = k2y_reg;
            seg_next.y1 = htc_pkg::ONE_Q15;
            seg_next.m0 = high_t_reg;
            seg_next.m1 = last_t_reg;
        end
        seg_next.d = x1 - x0;
        x0n      = PW'(x0) * N_P;
        num_next = pos - x0n;
        den_next = PW'(seg_next.d) * N_P;
    end

    // divider stages
    logic                vd_reg  [0:DS];
    logic [PW-1:0]       rem_reg [0:DS];
    logic [PW-1:0]       den_reg [0:DS];
    logic [15:0]         q_reg   [0:DS];
    htc_pkg::seg_t       seg_reg [0:DS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg[0] <= 1'b0;
        else
            vd_reg[0] <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num_next;
        den_reg[0] <= den_next;
        q_reg[0]   <= 16'd0;
        seg_reg[0] <= seg_next;
    end

    for (genvar g = 1; g <= DS; g++)
    begin : g_div
        logic [PW:0]   rshl;
        logic          rge;
        logic [PW-1:0] rem_next;

        assign rshl     = {rem_reg[g-1], 1'b0};
        assign rge      = rshl >= {1'b0, den_reg[g-1]};
        assign rem_next = rge ? PW'(rshl - {1'b0, den_reg[g-1]}) : rshl[PW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vd_reg[g] <= 1'b0;
            else
                vd_reg[g] <= vd_reg[g-1];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g] <= rem_next;
            den_reg[g] <= den_reg[g-1];
            q_reg[g]   <= {q_reg[g-1][14:0], rge};
            seg_reg[g] <= seg_reg[g-1];
        end
    end

    // polynomial stages
    logic               v1_reg, v2_reg, v3_reg, v4_reg, done_reg;
    logic [15:0]        t1_reg, t2a_reg, t2_reg, t2b_reg, t3_reg;
    logic [15:0]        y0a_reg, y1a_reg, y0b_reg, y1b_reg;
    logic signed [49:0] a0_reg, a1_reg;
    logic signed [33:0] a0s_reg, a1s_reg;
    logic [31:0]        tsq, tcu;
    logic signed [49:0] a0_next, a1_next;
    logic signed [18:0] te, t2e, t3e, h00, h10, h01, h11;
    logic signed [36:0] p0_reg, p2_reg, p0_next, p2_next;
    logic signed [52:0] p1_reg, p3_reg, p1_next, p3_next;
    logic signed [39:0] f0, f1, f2, f3, v_reg, v_next;
    logic [24:0]        w;
    logic [7:0]         level_reg, level_next;
    logic               clipped_reg, clipped_next;

    assign tsq     = 32'(q_reg[DS]) * 32'(q_reg[DS]);
    assign a0_next = 50'($signed({1'b0, seg_reg[DS].d, 1'b0}))
                   * 50'($signed(seg_reg[DS].m0));
    assign a1_next = 50'($signed({1'b0, seg_reg[DS].d, 1'b0}))
                   * 50'($signed(seg_reg[DS].m1));
    assign tcu     = 32'(t2a_reg) * 32'(t1_reg);

    assign te  = 19'(t2_reg);
    assign t2e = 19'(t2b_reg);
    assign t3e = 19'(t3_reg);
    assign h00 = (t3e <<< 1) - (t2e * 19'sd3) + 19'sd65536;
    assign h10 = t3e - (t2e <<< 1) + te;
    assign h01 = (t2e * 19'sd3) - (t3e <<< 1);
    assign h11 = t3e - t2e;

    assign p0_next = 37'($signed({1'b0, y0b_reg, 1'b0})) * 37'(h00);
    assign p2_next = 37'($signed({1'b0, y1b_reg, 1'b0})) * 37'(h01);
    assign p1_next = 53'(a0s_reg) * 53'(h10);
    assign p3_next = 53'(a1s_reg) * 53'(h11);

    assign f0     = 40'($signed(p0_reg[36:16]));
    assign f1     = 40'($signed(p1_reg[52:16]));
    assign f2     = 40'($signed(p2_reg[36:16]));
    assign f3     = 40'($signed(p3_reg[52:16]));
    assign v_next = f0 + f1 + f2 + f3;

    assign w = 25'(v_reg[16:0]) * 25'd255;

    always_comb
    begin
        if (v_reg[39])
        begin
            level_next   = 8'd0;
            clipped_next = 1'b1;
        end
        else if (v_reg > 40'sd65536)
        begin
            level_next   = 8'd255;
            clipped_next = 1'b1;
        end
        else
        begin
            level_next   = w[23:16];
            clipped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= vd_reg[DS];
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg      <= q_reg[DS];
        t2a_reg     <= tsq[31:16];
        a0_reg      <= a0_next;
        a1_reg      <= a1_next;
        y0a_reg     <= seg_reg[DS].y0;
        y1a_reg     <= seg_reg[DS].y1;
        t2_reg      <= t1_reg;
        t2b_reg     <= t2a_reg;
        t3_reg      <= tcu[31:16];
        a0s_reg     <= a0_reg[49:16];
        a1s_reg     <= a1_reg[49:16];
        y0b_reg     <= y0a_reg;
        y1b_reg     <= y1a_reg;
        p0_reg      <= p0_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        p3_reg      <= p3_next;
        v_reg       <= v_next;
        level_reg   <= level_next;
        clipped_reg <= clipped_next;
    end

    assign done    = done_reg;
    assign level   = level_reg;
    assign clipped = clipped_reg;

endmodule
